// File: rtl/gsea_pkg.sv
// Shared types and constants for the gene set enrichment score block.
// Used by gsea_div and gene_set_enrichment_score; depends on nothing.
package gsea_pkg;

    localparam int GENE_DEPTH = 16384;
    localparam int GENE_AW    = $clog2(GENE_DEPTH);
    localparam int DIV_W      = 64;
    localparam int DVS_W      = 48;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_HEADER = 2'd1;
    localparam logic [1:0] ACT_MEMBER = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SCORE  = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    localparam logic CFG_RANK_SUM     = 1'b0;
    localparam logic CFG_SMALLEST_SET = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [GENE_AW-1:0] gene_index;
        logic signed [31:0] rank_value;
        logic signed [31:0] gene_value;
        logic [14:0]        set_size;
        logic [15:0]        set_weight;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] score;
        logic [1:0]         status;
        logic [14:0]        kept_size;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/gsea_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on gsea_pkg for widths and the status struct.
module gsea_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gsea_pkg::DIV_W-1:0]  dividend,
    input  logic [gsea_pkg::DVS_W-1:0]  divisor,
    output gsea_pkg::div_status_t       stat,
    output logic [gsea_pkg::DIV_W-1:0]  quotient
);
    import gsea_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: rtl/gene_set_enrichment_score.sv
// Top level of the gene set enrichment score block: gene tables, sequencer, accumulators.
// Depends on gsea_pkg and gsea_div.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_item_t
// m_        out        m_valid / m_ready  out_item_t
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// A load or header completes when it is accepted; a member takes three steps (table read,
// multiply, accumulate). The last member of a set adds two passes through the shared
// divider unless the set's value total is zero. Reset is synchronous and clears
// the sequencer and totals; the tables hold nothing until loaded. A result that is not
// taken holds the block until its transfer.
module gene_set_enrichment_score (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gsea_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gsea_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [47:0]         cfg_data
);
    import gsea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_DIV1, S_DIV2, S_EMIT
    } state_t;

    state_t             state_reg;
    logic signed [47:0] rank_sum_reg;
    logic [14:0]        smallest_reg;
    logic signed [47:0] rtot_reg, vtot_reg;
    logic signed [63:0] ptot_reg, prod_reg;
    logic [14:0]        left_reg, size_reg;
    logic [15:0]        weight_reg;
    logic               skip_reg;
    logic [63:0]        rd_reg;
    logic [63:0]        mem [GENE_DEPTH];
    logic signed [51:0] t1_reg;
    logic [1:0]         status_reg;
    logic signed [47:0] score_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic               accept, out_free;
    logic               too_small, emit_now;
    logic signed [64:0] psum;
    logic signed [63:0] psat;
    div_status_t        dstat;
    logic               div_start;
    logic [63:0]        div_dvd, quo;
    logic [47:0]        div_dvs;
    logic [63:0]        pmag;
    logic [47:0]        vmag;
    logic signed [48:0] diff;
    logic [48:0]        dmag;
    logic [50:0]        t1mag;
    logic signed [51:0] t1;
    logic signed [49:0] t2;
    logic signed [52:0] ssum;
    logic signed [47:0] ssat;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign too_small = (s_data.set_size == '0) || (s_data.set_size < smallest_reg);
    assign emit_now  = (accept && s_data.action == ACT_HEADER && too_small)
                    || (state_reg == S_EMIT && out_free);

    always_ff @(posedge aclk) begin
        if (accept && s_data.action == ACT_LOAD) begin
            mem[s_data.gene_index] <= {s_data.rank_value, s_data.gene_value};
        end
        rd_reg <= mem[s_data.gene_index];
    end

    assign psum = {ptot_reg[63], ptot_reg} + {prod_reg[63], prod_reg};
    assign psat = (psum[64] != psum[63]) ?
                  (psum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : psum[63:0];

    assign pmag = psat[63] ? 64'(-psat) : 64'(psat);
    assign vmag = vtot_reg[47] ? 48'(-vtot_reg) : 48'(vtot_reg);
    assign diff = {rtot_reg[47], rtot_reg} - {rank_sum_reg[47], rank_sum_reg};
    assign dmag = diff[48] ? 49'(-diff) : 49'(diff);

    assign div_start = (state_reg == S_ACC && left_reg == '0 && vtot_reg != '0)
                    || (state_reg == S_DIV1 && dstat.done);
    assign div_dvd   = (state_reg == S_ACC) ? pmag : {15'd0, dmag};
    assign div_dvs   = (state_reg == S_ACC) ? vmag : {32'd0, weight_reg};

    gsea_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (dstat),
        .quotient (quo)
    );

    assign t1mag = (quo > (64'd1 << 50)) ? (51'd1 << 50) : quo[50:0];
    assign t1    = (ptot_reg[63] != vtot_reg[47]) ? -$signed({1'b0, t1mag})
                                                  : $signed({1'b0, t1mag});
    assign t2    = diff[48] ? -$signed({1'b0, quo[48:0]}) : $signed({1'b0, quo[48:0]});
    assign ssum  = {t1_reg[51], t1_reg} + {{3{t2[49]}}, t2};
    assign ssat  = (ssum[52:47] == 6'b000000 || ssum[52:47] == 6'b111111) ? ssum[47:0]
                 : (ssum[52] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rank_sum_reg  <= '0;
            smallest_reg  <= 15'd1;
            rtot_reg      <= '0;
            vtot_reg      <= '0;
            ptot_reg      <= '0;
            left_reg      <= '0;
            size_reg      <= '0;
            weight_reg    <= 16'd1;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RANK_SUM:     rank_sum_reg <= cfg_data;
                    CFG_SMALLEST_SET: smallest_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (emit_now) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && s_data.action == ACT_HEADER) begin
                        rtot_reg   <= '0;
                        vtot_reg   <= '0;
                        ptot_reg   <= '0;
                        weight_reg <= (s_data.set_weight == '0) ? 16'd1 : s_data.set_weight;
                        left_reg   <= s_data.set_size;
                        if (too_small) begin
                            size_reg <= '0;
                            skip_reg <= (s_data.set_size != '0);
                            out_reg  <= '{score: '0, status: ST_TOO_SMALL, kept_size: '0};
                        end else begin
                            size_reg <= s_data.set_size;
                            skip_reg <= 1'b0;
                        end
                    end else if (accept && s_data.action == ACT_MEMBER && left_reg != '0) begin
                        left_reg <= left_reg - 1'b1;
                        if (skip_reg) begin
                            if (left_reg == 15'd1) begin
                                skip_reg <= 1'b0;
                            end
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= $signed(rd_reg[63:32]) * $signed(rd_reg[31:0]);
                    rtot_reg  <= rtot_reg + {{16{rd_reg[63]}}, rd_reg[63:32]};
                    vtot_reg  <= vtot_reg + {{16{rd_reg[31]}}, rd_reg[31:0]};
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    ptot_reg <= psat;
                    if (left_reg != '0) begin
                        state_reg <= S_IDLE;
                    end else if (vtot_reg == '0) begin
                        status_reg <= ST_NO_SCORE;
                        score_reg  <= '0;
                        state_reg  <= S_EMIT;
                    end else begin
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (dstat.done) begin
                        t1_reg    <= t1;
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (dstat.done) begin
                        score_reg  <= ssat;
                        status_reg <= ST_OK;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_reg   <= '{score: score_reg, status: status_reg,
                                       kept_size: size_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_score_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.score == '0)
        else $error("score not zero on a failed status");
    a_kept_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_TOO_SMALL |-> m_data.kept_size != '0)
        else $error("scored set reports zero kept size");
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.busy |-> state_reg == S_DIV1 || state_reg == S_DIV2)
        else $error("divider busy outside a division step");
    a_acc_follows_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |=> state_reg == S_ACC)
        else $error("multiply step not followed by accumulate");

endmodule

// File: test/testbench.sv
// Self-checking testbench for gene_set_enrichment_score: loads gene tables, scores sets.
// Depends on gsea_pkg and the block's RTL; predicts each result and compares it on transfer.
module testbench;
    import gsea_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NGENES = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [47:0] cfg_data = '0;

    logic signed [31:0] rank_mem [0:GENE_DEPTH-1];
    logic signed [31:0] value_mem [0:GENE_DEPTH-1];
    logic signed [47:0] rank_acc, value_acc, rank_offset;
    logic signed [63:0] product_acc;
    int                 members_pending, weight_now, size_now, min_members;
    bit                 dropping;
    out_item_t          expected_scores [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    int                 touched_genes [$];

    gene_set_enrichment_score i_dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, compare each transfer with the oldest expectation.
    initial begin
        int        gap;
        out_item_t want;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = expected_scores.pop_front();
                if (want !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, m_data);
                end
            end
        end
    end

    function automatic logic signed [47:0] enrichment(input logic signed [63:0] pr,
            input logic signed [47:0] vs, input logic signed [47:0] rs,
            input logic signed [47:0] off, input int w);
        logic [63:0]        q, pm, vm;
        logic signed [63:0] t1, t2, s;
        pm = pr < 0 ? -pr : pr;
        vm = vs < 0 ? -64'(vs) : 64'(vs);
        q = pm / vm;
        t1 = q > (64'd1 << 50) ? 64'sd1 <<< 50 : $signed(q);
        if ((pr < 0) != (vs < 0)) t1 = -t1;
        t2 = (64'(rs) - 64'(off)) / w;
        s = t1 + t2;
        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
        return s[47:0];
    endfunction

    task automatic predict_score(input in_item_t it);
        logic signed [63:0] r, y, p, sum;
        if (it.action == ACT_LOAD) begin
            rank_mem[it.gene_index] = it.rank_value;
            value_mem[it.gene_index] = it.gene_value;
        end else if (it.action == ACT_HEADER) begin
            rank_acc = 0; value_acc = 0; product_acc = 0;
            weight_now = it.set_weight == 0 ? 1 : it.set_weight;
            members_pending = it.set_size;
            if (it.set_size == 0 || it.set_size < min_members) begin
                size_now = 0;
                dropping = it.set_size != 0;
                expected_scores.push_back('{score: '0, status: ST_TOO_SMALL, kept_size: '0});
            end else begin
                size_now = it.set_size;
                dropping = 1'b0;
            end
        end else if (it.action == ACT_MEMBER && members_pending != 0) begin
            members_pending--;
            if (!dropping) begin
                r = rank_mem[it.gene_index];
                y = value_mem[it.gene_index];
                rank_acc += 48'(r);
                value_acc += 48'(y);
                p = r * y;
                sum = product_acc + p;
                if (p > 0 && product_acc > 0 && sum < 0) sum = 64'h7FFF_FFFF_FFFF_FFFF;
                if (p < 0 && product_acc < 0 && sum >= 0) sum = 64'h8000_0000_0000_0000;
                product_acc = sum;
            end
            if (members_pending == 0) begin
                if (dropping) dropping = 1'b0;
                else if (value_acc == 0)
                    expected_scores.push_back('{score: '0, status: ST_NO_SCORE,
                                                kept_size: 15'(size_now)});
                else
                    expected_scores.push_back('{score: enrichment(product_acc, value_acc,
                        rank_acc, rank_offset, weight_now), status: ST_OK,
                        kept_size: 15'(size_now)});
            end
        end
    endtask

    task automatic send_item(input in_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk iff s_ready);
        predict_score(it);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        wait (expected_scores.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [47:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_RANK_SUM) rank_offset = val;
        else min_members = val[14:0];
        @(posedge aclk);
    endtask

    function automatic in_item_t rand_item();
        logic [127:0] raw;
        in_item_t     it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    task automatic load_gene(input int g, input logic [31:0] r, input logic [31:0] y);
        in_item_t it;
        it = rand_item();
        it.action = ACT_LOAD; it.gene_index = GENE_AW'(g); it.rank_value = r;
        it.gene_value = y;
        send_item(it);
    endtask

    task automatic send_header(input int size, input int w);
        in_item_t it;
        it = rand_item();
        it.action = ACT_HEADER; it.set_size = 15'(size); it.set_weight = 16'(w);
        send_item(it);
    endtask

    function automatic int pick_gene();
        return touched_genes[$urandom_range(0, touched_genes.size() - 1)];
    endfunction

    task automatic send_member(input int g);
        in_item_t it;
        it = rand_item();
        it.action = ACT_MEMBER; it.gene_index = GENE_AW'(g);
        send_item(it);
    endtask

    task automatic test_table_load();
        for (int g = 0; g < NGENES; g++) begin
            load_gene(g, $urandom, $urandom);
            touched_genes.push_back(g);
        end
        load_gene(GENE_DEPTH - 1, 32'h8000_0000, 32'h8000_0000);
        touched_genes.push_back(GENE_DEPTH - 1);
        load_gene(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_gene(2, 32'h0001_0000, 32'h0);
        load_gene(3, 32'hFFFF_0000, 32'h0);
    endtask

    task automatic test_directed_sets();
        in_item_t it;
        send_header(1, 0);
        send_member(2);
        send_header(2, 65535);
        send_member(GENE_DEPTH - 1);
        send_member(GENE_DEPTH - 1);
        send_header(3, 1);
        send_member(1); send_member(1); send_member(GENE_DEPTH - 1);
        send_header(0, 5);
        send_member(4);
        send_header(4, 7);
        send_member(5);
        send_header(2, 3);
        send_member(2); send_member(3);
        it = rand_item(); it.action = ACT_NONE; send_item(it);
        send_member(6);
    endtask

    task automatic test_small_sets();
        send_header(2, 9);
        send_member(7); send_member(8);
        send_header(5, 1);
        send_member(9); send_member(10);
    endtask

    task automatic test_random_sets(input int count);
        int n, k;
        in_item_t it;
        for (n = 0; n < count; ) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                int sz;
                sz = $urandom_range(1, 12);
                send_header(sz, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535));
                n++;
                for (int m = 0; m < sz && !($urandom_range(0, 40) == 0); m++) begin
                    send_member(pick_gene());
                    n++;
                end
            end else if (k == 7) begin
                int g;
                g = $urandom_range(0, GENE_DEPTH - 1);
                load_gene(g, $urandom, $urandom);
                touched_genes.push_back(g);
                n++;
            end else begin
                it = rand_item();
                if (it.action == ACT_MEMBER) it.gene_index = GENE_AW'(pick_gene());
                if (it.action == ACT_HEADER) it.set_size = 15'($urandom_range(0, 16));
                send_item(it);
                n++;
            end
        end
    endtask

    initial begin
        rank_offset = 0; min_members = 1; members_pending = 0; weight_now = 1;
        size_now = 0; dropping = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_load();
        test_directed_sets();
        drain_results();
        write_register(CFG_SMALLEST_SET, 48'd4);
        write_register(CFG_RANK_SUM, 48'h8000_0000_0000);
        test_small_sets();
        drain_results();
        write_register(CFG_RANK_SUM, 48'h7FFF_FFFF_FFFF);
        write_register(CFG_SMALLEST_SET, 48'd16384);
        send_header(16383, 2);
        send_header(3, 2);
        drain_results();
        write_register(CFG_SMALLEST_SET, 48'd0);
        write_register(CFG_RANK_SUM, {$urandom, $urandom});
        test_random_sets(550);
        drain_results();
        write_register(CFG_SMALLEST_SET, 48'd3);
        write_register(CFG_RANK_SUM, 48'd0);
        test_random_sets(550);
        drain_results();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
